// ----- sv/psrl_pkg.sv -----
// ---------------------------------------------------------------------------
// psrl_pkg: shared types and constants for the per-source rate limiter
// Verdict codes, register indexes, table size and the request, carry and
// commit structures passed along the row of source cells.
// ---------------------------------------------------------------------------
`default_nettype none

package psrl_pkg;

    // Table size (number of source cells)
    localparam int PEER_SLOTS = 20;

    // Field widths
    localparam int ADDR_W    = 48;
    localparam int TIME_W    = 32;
    localparam int BYTE_W    = 8;
    localparam int COUNT_W   = 8;
    localparam int WINDOW_W  = 16;
    localparam int VERDICT_W = 3;
    localparam int SLOT_W    = 5;

    // Stream and configuration widths
    localparam int S_DATA_W  = 96;
    localparam int M_DATA_W  = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;

    // Reset values of the registers
    localparam logic [COUNT_W-1:0]  RATE_LIMIT_RST = 8'd10;
    localparam logic [WINDOW_W-1:0] WINDOW_MS_RST  = 16'd1000;

    // Payload action
    localparam logic [BYTE_W-1:0] CMD_FLASH = 8'd1;
    localparam logic [BYTE_W-1:0] FLASH_LEN = 8'd2;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATE_LIMIT = 1'b0,
        CFG_WINDOW_MS  = 1'b1
    } cfg_index_t;

    // Verdict codes
    typedef enum logic [VERDICT_W-1:0] {
        V_ACCEPT    = 3'd0,
        V_NEW       = 3'd1,
        V_BLOCKED   = 3'd2,
        V_NEW_BLOCK = 3'd3,
        V_FULL      = 3'd4
    } verdict_t;

    // Request held while the row evaluates it, plus the live settings
    typedef struct packed {
        logic [ADDR_W-1:0]   addr;
        logic [TIME_W-1:0]   now;
        logic [BYTE_W-1:0]   cmd;
        logic [BYTE_W-1:0]   len;
        logic [COUNT_W-1:0]  rate_limit;
        logic [WINDOW_W-1:0] window_ms;
    } req_t;

    // Handed from cell to cell along the row
    typedef struct packed {
        logic              hit;
        verdict_t          verdict;
        logic [SLOT_W-1:0] slot;
        logic              pulse;
        logic              free_seen;
        logic [SLOT_W-1:0] spare_slot;
    } carry_t;

    // Broadcast back to every cell at the end of evaluation
    typedef struct packed {
        logic fire;   // request completes this cycle
        logic alloc;  // no cell matched: lowest free cell takes the source
    } commit_t;

endpackage

`default_nettype wire

// ----- sv/psrl_cell.sv -----
// ---------------------------------------------------------------------------
// psrl_cell: one source entry of the rate limiter row
// Holds address, count, window start and marks for one source; compares the
// request against its entry and passes match and free-slot results onwards.
// ---------------------------------------------------------------------------
`default_nettype none

module psrl_cell
    import psrl_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [SLOT_W-1:0] cell_slot,
    input  wire req_t              req,
    input  wire commit_t           commit,
    input  wire carry_t            carry_in,
    output carry_t                 carry_out,
    output logic                   match
);

    logic                valid_reg,   valid_next;
    logic                blocked_reg, blocked_next;
    logic [ADDR_W-1:0]   addr_reg,    addr_next;
    logic [COUNT_W-1:0]  count_reg,   count_next;
    logic [TIME_W-1:0]   start_reg,   start_next;

    logic [TIME_W-1:0]   elapsed;
    logic                restart;
    logic [COUNT_W-1:0]  base_count;
    logic [COUNT_W-1:0]  inc_count;
    logic                new_block;
    logic                take_free;
    verdict_t            local_verdict;
    logic                local_pulse;

    // Match and window arithmetic
    always_comb begin
        match      = valid_reg && (addr_reg == req.addr);
        elapsed    = req.now - start_reg;
        restart    = elapsed > {{(TIME_W-WINDOW_W){1'b0}}, req.window_ms};
        base_count = restart ? '0 : count_reg;
        inc_count  = (base_count == COUNT_MAX) ? COUNT_MAX : base_count + 8'd1;
        new_block  = inc_count > req.rate_limit;
        take_free  = !carry_in.free_seen && !valid_reg;
    end

    // Verdict for a request that matches this entry
    always_comb begin
        local_pulse = 1'b0;
        if (blocked_reg) begin
            local_verdict = V_BLOCKED;
        end else if (new_block) begin
            local_verdict = V_NEW_BLOCK;
        end else begin
            local_verdict = V_ACCEPT;
            local_pulse   = (req.len == FLASH_LEN) && (req.cmd == CMD_FLASH);
        end
    end

    // Pass results to the neighbour
    always_comb begin
        carry_out = carry_in;
        if (match) begin
            carry_out.hit     = 1'b1;
            carry_out.verdict = local_verdict;
            carry_out.slot    = cell_slot;
            carry_out.pulse   = local_pulse;
        end
        if (take_free) begin
            carry_out.free_seen  = 1'b1;
            carry_out.spare_slot = cell_slot;
        end
    end

    // Entry update
    always_comb begin
        valid_next   = valid_reg;
        blocked_next = blocked_reg;
        addr_next    = addr_reg;
        count_next   = count_reg;
        start_next   = start_reg;
        if (commit.fire && match && !blocked_reg) begin
            count_next   = inc_count;
            start_next   = restart ? req.now : start_reg;
            blocked_next = new_block;
        end else if (commit.fire && commit.alloc && take_free) begin
            valid_next   = 1'b1;
            blocked_next = 1'b0;
            addr_next    = req.addr;
            count_next   = 8'd1;
            start_next   = req.now;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= 1'b0;
            blocked_reg <= 1'b0;
        end else begin
            valid_reg   <= valid_next;
            blocked_reg <= blocked_next;
        end
        addr_reg  <= addr_next;
        count_reg <= count_next;
        start_reg <= start_next;
    end

endmodule

`default_nettype wire

// ----- sv/per_source_rate_limiter_unit.sv -----
// ---------------------------------------------------------------------------
// per_source_rate_limiter_unit: per-source fixed-window frame rate limiter
// Frames are checked against a row of source cells; each frame of nonzero length gives one verdict.
// ---------------------------------------------------------------------------
//  channel  | dir | handshake            | payload
//  s_       | in  | s_tvalid / s_tready  | s_tdata: addr, now_ms, cmd, len
//  m_       | out | m_tvalid / m_tready  | m_tdata: verdict, slot, flash_pulse
//  cfg_     | in  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  A frame is accepted in IDLE; in EVAL the cell row matches, updates and
//  finds the lowest free entry, and the verdict is registered.
//  A frame of length zero gives no verdict and never waits on the output;
//  other frames wait in EVAL while the output register holds an untaken verdict.
//  Synchronous active-low reset clears all entries at once; no sweep.
//  cfg_ready is always high.
// ---------------------------------------------------------------------------
`default_nettype none

module per_source_rate_limiter_unit
    import psrl_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // [47:0] source_addr, [79:48] now_ms, [87:80] cmd_byte, [95:88] frame_len
    input  wire logic [S_DATA_W-1:0]  s_tdata,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [2:0] verdict, [7:3] slot, [8] flash_pulse, [15:9] zero
    output logic [M_DATA_W-1:0]       m_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data
);

    typedef enum logic {
        IDLE,
        EVAL
    } state_t;

    state_t               state_reg;
    logic [COUNT_W-1:0]   rate_limit_reg;
    logic [WINDOW_W-1:0]  window_ms_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic [TIME_W-1:0]    now_reg;
    logic [BYTE_W-1:0]    cmd_reg;
    logic [BYTE_W-1:0]    len_reg;
    logic                 out_valid_reg;
    logic [M_DATA_W-1:0]  out_data_reg;

    req_t                 req;
    commit_t              commit;
    carry_t               chain [PEER_SLOTS+1];
    logic [PEER_SLOTS-1:0] match_vec;
    logic                 out_free;
    logic                 s_fire;
    carry_t               row_end;
    verdict_t             res_verdict;
    logic [SLOT_W-1:0]    res_slot;
    logic                 res_pulse;

    // Handshakes
    assign s_tready  = (state_reg == IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign out_free  = !out_valid_reg || m_tready;

    // Request broadcast to the row
    always_comb begin
        req.addr       = addr_reg;
        req.now        = now_reg;
        req.cmd        = cmd_reg;
        req.len        = len_reg;
        req.rate_limit = rate_limit_reg;
        req.window_ms  = window_ms_reg;
    end

    assign row_end = chain[PEER_SLOTS];
    assign commit  = '{fire:  (state_reg == EVAL) && out_free && (len_reg != '0),
                       alloc: !row_end.hit};

    // Row of source cells
    assign chain[0] = '0;
    for (genvar k = 0; k < PEER_SLOTS; k++) begin : g_cell
        psrl_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cell_slot (SLOT_W'(k)),
            .req       (req),
            .commit    (commit),
            .carry_in  (chain[k]),
            .carry_out (chain[k+1]),
            .match     (match_vec[k])
        );
    end

    // Final verdict from the end of the row
    always_comb begin
        res_pulse = 1'b0;
        if (row_end.hit) begin
            res_verdict = row_end.verdict;
            res_slot    = row_end.slot;
            res_pulse   = row_end.pulse;
        end else if (row_end.free_seen) begin
            res_verdict = V_NEW;
            res_slot    = row_end.spare_slot;
        end else begin
            res_verdict = V_FULL;
            res_slot    = '0;
        end
    end

    // Control, request capture, output register and settings
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= IDLE;
            out_valid_reg  <= 1'b0;
            rate_limit_reg <= RATE_LIMIT_RST;
            window_ms_reg  <= WINDOW_MS_RST;
        end else begin
            // output register: load on completion, clear once taken
            if (commit.fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                IDLE: begin
                    if (s_fire) begin
                        state_reg <= EVAL;
                    end
                end
                EVAL: begin
                    if (len_reg == '0) begin
                        state_reg <= IDLE;
                    end else if (out_free) begin
                        state_reg <= IDLE;
                    end
                end
                default: state_reg <= IDLE;
            endcase
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_RATE_LIMIT: rate_limit_reg <= cfg_data[COUNT_W-1:0];
                    CFG_WINDOW_MS:  window_ms_reg  <= cfg_data[WINDOW_W-1:0];
                    default: ;
                endcase
            end
        end
        if (s_fire) begin
            addr_reg <= s_tdata[47:0];
            now_reg  <= s_tdata[79:48];
            cmd_reg  <= s_tdata[87:80];
            len_reg  <= s_tdata[95:88];
        end
        if (commit.fire) begin
            out_data_reg <= {7'd0, res_pulse, res_slot, res_verdict};
        end
    end

    // Checks
    a_one_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == EVAL) |-> $onehot0(match_vec))
        else $error("more than one cell matches the source address");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_tready)
        else $error("request accepted while the previous one is still evaluated");

    a_result_from_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !$past(m_tvalid)) |-> $past(state_reg == EVAL))
        else $error("verdict appeared without an evaluation cycle");

    a_pulse_only_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[8]) |-> (m_tdata[2:0] == V_ACCEPT))
        else $error("flash pulse on a frame that was not accepted");

endmodule

`default_nettype wire

// ----- verif/tb_per_source_rate_limiter_unit.sv -----
// ---------------------------------------------------------------------------
// tb_per_source_rate_limiter_unit: self-checking bench for the rate limiter
// Frames go in on the s_ stream and verdicts come back on the m_ stream. A
// local model of the source table predicts every verdict when a frame is
// taken, and a checker compares each verdict, field by field, with the
// oldest prediction. Directed tests cover address, time and length extremes,
// the flash command, window edges and out-of-range limits. A long run on one
// source covers the count ceiling. Random phases then run bursts from a pool
// of sources under several settings, with random idling on both sides.
// ---------------------------------------------------------------------------
module tb_per_source_rate_limiter_unit;
    import psrl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Fixed source addresses used by the directed tests
    localparam logic [ADDR_W-1:0] ADDR_LOW  = 48'h0000_0000_0000;
    localparam logic [ADDR_W-1:0] ADDR_HIGH = 48'hFFFF_FFFF_FFFF;
    localparam logic [ADDR_W-1:0] ADDR_A    = 48'h0123_4567_89AB;
    localparam logic [ADDR_W-1:0] ADDR_B    = 48'h0200_0000_00B0;
    localparam logic [ADDR_W-1:0] ADDR_C    = 48'h8000_0000_0001;
    localparam logic [ADDR_W-1:0] ADDR_D    = 48'h7EAD_BEEF_0042;

    // One predicted verdict
    typedef struct packed {
        verdict_t          verdict;
        logic [SLOT_W-1:0] slot;
        logic              pulse;
    } verdict_rec_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic [S_DATA_W-1:0]  s_tdata   = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_RATE_LIMIT;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    // Local copy of the source table and the settings
    logic                 src_valid   [PEER_SLOTS];
    logic [ADDR_W-1:0]    known_addr  [PEER_SLOTS];
    logic [COUNT_W-1:0]   src_count   [PEER_SLOTS];
    logic [TIME_W-1:0]    src_start   [PEER_SLOTS];
    logic                 src_blocked [PEER_SLOTS];
    logic [COUNT_W-1:0]   cur_limit  = RATE_LIMIT_RST;
    logic [WINDOW_W-1:0]  cur_window = WINDOW_MS_RST;

    verdict_rec_t         pending_verdicts[$];
    logic [ADDR_W-1:0]    addr_pool[$];
    int                   fail_count = 0;
    bit                   calm = 1'b0;

    per_source_rate_limiter_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Random idling, switched off during calm stretches
    function automatic bit take_break();
        return !calm && ($urandom_range(0, 99) < 13);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        fail_count++;
    endtask

    // Verdict of one frame; updates the local table. Returns 0 for no verdict.
    function automatic bit judge_frame(input logic [ADDR_W-1:0] addr,
                                       input logic [TIME_W-1:0] now,
                                       input logic [BYTE_W-1:0] cmd,
                                       input logic [BYTE_W-1:0] len,
                                       output verdict_rec_t rec);
        int          free_idx;
        logic [31:0] elapsed;
        free_idx = -1;
        rec = '0;
        if (len == '0)
            return 1'b0;
        for (int k = 0; k < PEER_SLOTS; k++) begin
            if (src_valid[k] && known_addr[k] == addr) begin
                rec.slot = SLOT_W'(k);
                if (src_blocked[k]) begin
                    rec.verdict = V_BLOCKED;
                    return 1'b1;
                end
                // window restart once strictly more than the window has gone
                elapsed = now - src_start[k];
                if (elapsed > {16'd0, cur_window}) begin
                    src_count[k] = '0;
                    src_start[k] = now;
                end
                if (src_count[k] != COUNT_MAX)
                    src_count[k] = src_count[k] + 8'd1;
                if (src_count[k] > cur_limit) begin
                    src_blocked[k] = 1'b1;
                    rec.verdict = V_NEW_BLOCK;
                    return 1'b1;
                end
                rec.verdict = V_ACCEPT;
                rec.pulse = (len == FLASH_LEN) && (cmd == CMD_FLASH);
                return 1'b1;
            end
            if (free_idx < 0 && !src_valid[k])
                free_idx = k;
        end
        if (free_idx < 0) begin
            rec.verdict = V_FULL;
            return 1'b1;
        end
        // unknown source takes the lowest free entry
        src_valid[free_idx]   = 1'b1;
        known_addr[free_idx]  = addr;
        src_count[free_idx]   = 8'd1;
        src_start[free_idx]   = now;
        src_blocked[free_idx] = 1'b0;
        rec.verdict = V_NEW;
        rec.slot = SLOT_W'(free_idx);
        return 1'b1;
    endfunction

    // Send one frame; the prediction is made at the accepting edge
    task automatic send_frame(input logic [ADDR_W-1:0] addr,
                              input logic [TIME_W-1:0] now,
                              input logic [BYTE_W-1:0] cmd,
                              input logic [BYTE_W-1:0] len);
        verdict_rec_t rec;
        while (take_break()) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata  <= {len, cmd, now, addr};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (judge_frame(addr, now, cmd, len, rec))
            pending_verdicts.push_back(rec);
    endtask

    // Wait until every verdict is in and the last frame has left the row
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_verdicts.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Write both registers while the block is idle
    task automatic set_limits(input logic [CFG_DAT_W-1:0] rate_word,
                              input logic [WINDOW_W-1:0]  win);
        settle();
        cfg_index <= CFG_RATE_LIMIT;
        cfg_data  <= rate_word;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cur_limit = rate_word[COUNT_W-1:0];
        cfg_index <= CFG_WINDOW_MS;
        cfg_data  <= win;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cur_window = win;
        cfg_valid <= 1'b0;
    endtask

    // Receiver side: random stalls
    always @(posedge aclk) begin
        m_tready <= aresetn && !take_break();
    end

    // Verdict checker
    always @(posedge aclk) begin
        verdict_rec_t exp_rec;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch($sformatf("verdict 0x%04h with no frame pending", m_tdata));
            end else begin
                exp_rec = pending_verdicts.pop_front();
                if (m_tdata[2:0] !== exp_rec.verdict)
                    report_mismatch($sformatf("verdict %0d, expected %0d",
                                              m_tdata[2:0], exp_rec.verdict));
                if (m_tdata[7:3] !== exp_rec.slot)
                    report_mismatch($sformatf("slot %0d, expected %0d",
                                              m_tdata[7:3], exp_rec.slot));
                if (m_tdata[8] !== exp_rec.pulse)
                    report_mismatch($sformatf("flash_pulse %0b, expected %0b",
                                              m_tdata[8], exp_rec.pulse));
                if (m_tdata[15:9] !== '0)
                    report_mismatch($sformatf("padding 0x%02h not zero", m_tdata[15:9]));
            end
        end
    end

    // Address and time extremes, the flash command and odd lengths,
    // all under the reset settings
    task automatic test_directed_frames();
        send_frame(ADDR_LOW, 32'd0, CMD_FLASH, FLASH_LEN);     // new: no action
        send_frame(ADDR_LOW, 32'd5, CMD_FLASH, FLASH_LEN);     // pulse
        send_frame(ADDR_HIGH, 32'hFFFF_FFF0, 8'hFF, 8'd250);
        send_frame(ADDR_HIGH, 32'h0000_0010, CMD_FLASH, FLASH_LEN); // wrap, no restart
        send_frame(ADDR_LOW, 32'd100, CMD_FLASH, 8'd1);
        send_frame(ADDR_LOW, 32'd101, CMD_FLASH, 8'd3);
        send_frame(ADDR_LOW, 32'd102, 8'd0, FLASH_LEN);
        send_frame(ADDR_LOW, 32'd103, CMD_FLASH, 8'd0);        // empty frame
        send_frame(ADDR_LOW, 32'd104, CMD_FLASH, 8'd251);      // long frame
        send_frame(ADDR_LOW, 32'd105, 8'd2, 8'd255);
    endtask

    // Window boundary, limit 0 and a zero window
    task automatic test_window_and_limit_edges();
        set_limits(16'd1, 16'd1);
        send_frame(ADDR_A, 32'd0, CMD_FLASH, FLASH_LEN);
        send_frame(ADDR_A, 32'd2, CMD_FLASH, FLASH_LEN);       // restart
        send_frame(ADDR_A, 32'd3, CMD_FLASH, FLASH_LEN);       // equal: no restart
        send_frame(ADDR_A, 32'd1000, CMD_FLASH, FLASH_LEN);    // stays blocked
        // limit 0, upper byte of the write ignored
        set_limits(16'hA500, 16'd1000);
        send_frame(ADDR_B, 32'd7, 8'd9, 8'd40);
        send_frame(ADDR_B, 32'd9000, 8'd9, 8'd40);
        // zero window
        set_limits(16'd3, 16'd0);
        send_frame(ADDR_C, 32'd50, 8'd0, 8'd10);
        send_frame(ADDR_C, 32'd50, CMD_FLASH, FLASH_LEN);
        send_frame(ADDR_C, 32'd51, CMD_FLASH, FLASH_LEN);
        send_frame(ADDR_C, 32'd51, 8'd0, 8'd10);
        send_frame(ADDR_C, 32'd51, 8'd0, 8'd10);
        send_frame(ADDR_C, 32'd51, 8'd0, 8'd10);
    endtask

    // Limit 255: the count saturates, then a lower limit blocks at once
    task automatic test_count_ceiling();
        logic [TIME_W-1:0] t;
        logic [BYTE_W-1:0] len;
        logic [BYTE_W-1:0] cmd;
        set_limits(16'h00FF, 16'hFFFF);
        t = 32'd7;
        send_frame(ADDR_D, t, 8'd0, 8'd1);
        repeat (259) begin
            t = t + $urandom_range(0, 190);
            cmd = $urandom_range(0, 3) == 0 ? CMD_FLASH : 8'($urandom_range(0, 255));
            len = $urandom_range(0, 2) == 0 ? FLASH_LEN : 8'($urandom_range(1, 250));
            send_frame(ADDR_D, t, cmd, len);
        end
        set_limits(16'd254, 16'hFFFF);
        send_frame(ADDR_D, t, 8'd0, 8'd1);
    endtask

    // Bursts from a pool of sources under several settings
    task automatic test_random_traffic();
        logic [TIME_W-1:0] now_cur;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] len;
        logic [BYTE_W-1:0] cmd;
        logic [7:0]        noise;
        int                sent;
        int                r;
        addr_pool = '{ADDR_LOW, ADDR_HIGH, ADDR_A, ADDR_B, ADDR_C, ADDR_D};
        repeat (20)
            addr_pool.push_back(ADDR_W'({$urandom(), $urandom()}));
        now_cur = $urandom();
        for (int p = 0; p < 6; p++) begin
            noise = 8'($urandom_range(0, 255));
            case (p)
                0: set_limits({noise, 8'd254}, 16'hFFFF);
                1: set_limits({noise, 8'($urandom_range(1, 254))},
                              WINDOW_W'($urandom_range(1, 65535)));
                2: set_limits(16'd10, 16'd1000);
                3: set_limits({noise, 8'($urandom_range(1, 20))},
                              WINDOW_W'($urandom_range(1, 2000)));
                4: set_limits(16'd5, 16'd300);
                default: set_limits({noise, 8'd1}, 16'd1);
            endcase
            calm = (p == 2);
            sent = 0;
            while (sent < 110) begin
                // mostly known sources, now and then an unknown one
                if ($urandom_range(0, 99) < 5)
                    addr = ADDR_W'({$urandom(), $urandom()});
                else
                    addr = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
                repeat ($urandom_range(1, 4)) begin
                    r = $urandom_range(0, 99);
                    if (r < 50)
                        now_cur = now_cur + $urandom_range(0, cur_window / 8);
                    else if (r < 75)
                        now_cur = now_cur + cur_window + $urandom_range(0, 2) - 1;
                    else if (r < 90)
                        now_cur = now_cur + $urandom_range(0, 3);
                    else if (r < 97)
                        now_cur = now_cur + $urandom();
                    else
                        now_cur = $urandom();
                    r = $urandom_range(0, 99);
                    cmd = 8'($urandom_range(0, 255));
                    if (r < 25) begin
                        cmd = CMD_FLASH;
                        len = FLASH_LEN;
                    end else if (r < 30) begin
                        len = 8'd0;
                    end else if (r < 35) begin
                        len = 8'($urandom_range(251, 255));
                    end else begin
                        len = 8'($urandom_range(1, 250));
                    end
                    send_frame(addr, now_cur, cmd, len);
                    if (len != 8'd0)
                        sent++;
                end
            end
        end
        calm = 1'b0;
    endtask

    // Main sequence
    initial begin
        for (int k = 0; k < PEER_SLOTS; k++) begin
            src_valid[k]   = 1'b0;
            known_addr[k]  = '0;
            src_count[k]   = '0;
            src_start[k]   = '0;
            src_blocked[k] = 1'b0;
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_frames();
        test_window_and_limit_edges();
        test_count_ceiling();
        test_random_traffic();

        // drain, then allow for the block's latency
        s_tvalid <= 1'b0;
        for (int n = 0; n < 5000 && pending_verdicts.size() != 0; n++)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (pending_verdicts.size() != 0)
            report_mismatch($sformatf("%0d verdicts never arrived", pending_verdicts.size()));

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/psrl_pkg.sv
sv/psrl_cell.sv
sv/per_source_rate_limiter_unit.sv
verif/tb_per_source_rate_limiter_unit.sv
